@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted
`define CHK_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds through reset
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/dchk_pkg.sv @@
// Shared types, codes and helper functions for the body dechunker
`default_nettype none

package dchk_pkg;

    localparam int DATA_W  = 8;
    localparam int CNT_W   = 32;
    localparam int ERR_W   = 2;
    localparam int PHASE_W = 3;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 32;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    localparam logic [PHASE_W-1:0] PH_SIZE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CR   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LF   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TERM = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_LINE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_BIG  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_TERM = 2'd3;

    localparam logic [CFG_A_W-1:0] CFG_BODY_MODE      = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_CONTENT_LENGTH = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_MAX_BODY_SIZE  = 2'd2;

    localparam logic [DATA_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [DATA_W-1:0] CHAR_LF = 8'h0A;

    localparam logic [CNT_W-1:0] MAX_BODY_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CNT_W-1:0]  body_count;
        logic [ERR_W-1:0]  error_code;
        logic              body_done;
        logic              payload_valid;
        logic [DATA_W-1:0] payload_byte;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [DATA_W-1:0] b);
        hex_t h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

@@ design/dchk_core.sv @@
// Per-byte parser state, configuration registers and result computation
`default_nettype none

module dchk_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_xfer,
    input  wire logic [dchk_pkg::DATA_W-1:0]   data_byte,
    input  wire logic                          new_body,
    input  wire logic                          cfg_we,
    input  wire logic [dchk_pkg::CFG_A_W-1:0]  cfg_addr,
    input  wire logic [dchk_pkg::CFG_D_W-1:0]  cfg_wdata,
    output dchk_pkg::result_t                  res
);
    import dchk_pkg::*;

    logic               body_mode_reg;
    logic [CNT_W-1:0]   content_length_reg;
    logic [CNT_W-1:0]   max_body_size_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               seen_reg, seen_next;
    logic               text_reg, text_next;
    logic               done_reg, done_next;
    logic [ERR_W-1:0]   err_reg, err_next;

    logic [PHASE_W-1:0] phase_cur;
    logic [CNT_W-1:0]   acc_cur, left_cur, total_cur;
    logic               seen_cur, text_cur, done_cur;
    logic [ERR_W-1:0]   err_cur;
    logic               valid;
    logic [CNT_W-1:0]   total_inc;
    logic [CNT_W:0]     size_sum;
    hex_t               hex;

    assign phase_cur = new_body ? PH_SIZE  : phase_reg;
    assign acc_cur   = new_body ? '0       : acc_reg;
    assign left_cur  = new_body ? '0       : left_reg;
    assign total_cur = new_body ? '0       : total_reg;
    assign seen_cur  = new_body ? 1'b0     : seen_reg;
    assign text_cur  = new_body ? 1'b0     : text_reg;
    assign done_cur  = new_body ? 1'b0     : done_reg;
    assign err_cur   = new_body ? ERR_NONE : err_reg;

    assign total_inc = total_cur + CNT_W'(1);
    assign size_sum  = {1'b0, total_cur} + {1'b0, acc_cur};
    assign hex       = hex_decode(data_byte);

    always_comb begin
        phase_next = phase_cur;
        acc_next   = acc_cur;
        left_next  = left_cur;
        total_next = total_cur;
        seen_next  = seen_cur;
        text_next  = text_cur;
        done_next  = done_cur;
        err_next   = err_cur;
        valid      = 1'b0;
        if (!done_cur && err_cur == ERR_NONE) begin
            if (!body_mode_reg) begin
                if (content_length_reg > max_body_size_reg) begin
                    err_next = ERR_TOO_BIG;
                end else if (total_cur >= content_length_reg) begin
                    done_next = 1'b1;
                end else begin
                    valid      = 1'b1;
                    total_next = total_inc;
                    if (total_inc == content_length_reg) begin
                        done_next = 1'b1;
                    end
                end
            end else begin
                unique case (phase_cur)
                    PH_DATA: begin
                        valid      = 1'b1;
                        total_next = total_inc;
                        left_next  = left_cur - CNT_W'(1);
                        if (left_cur == CNT_W'(1)) begin
                            phase_next = PH_CR;
                        end
                    end
                    PH_CR: begin
                        if (data_byte == CHAR_CR) phase_next = PH_LF;
                        else err_next = ERR_BAD_LINE;
                    end
                    PH_LF: begin
                        if (data_byte == CHAR_LF) phase_next = PH_SIZE;
                        else err_next = ERR_BAD_LINE;
                    end
                    PH_TERM: begin
                        if (data_byte == CHAR_LF) done_next = 1'b1;
                        else if (data_byte != CHAR_CR) err_next = ERR_BAD_TERM;
                    end
                    default: begin
                        phase_next = PH_SIZE;
                        if (data_byte == CHAR_CR) begin
                            phase_next = PH_SIZE;
                        end else if (data_byte == CHAR_LF) begin
                            if (!seen_cur) begin
                                if (text_cur) err_next = ERR_BAD_LINE;
                                text_next = 1'b0;
                            end else if (size_sum > {1'b0, max_body_size_reg}) begin
                                err_next = ERR_TOO_BIG;
                            end else begin
                                left_next  = acc_cur;
                                phase_next = (acc_cur == '0) ? PH_TERM : PH_DATA;
                                acc_next   = '0;
                                seen_next  = 1'b0;
                                text_next  = 1'b0;
                            end
                        end else if (!hex.is_hex || text_cur) begin
                            text_next = 1'b1;
                        end else if (acc_cur[CNT_W-1 -: 4] != 4'd0) begin
                            err_next = ERR_TOO_BIG;
                        end else begin
                            acc_next  = {acc_cur[CNT_W-5:0], hex.value};
                            seen_next = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        res.payload_byte  = data_byte;
        res.payload_valid = valid;
        res.body_done     = done_next;
        res.error_code    = err_next;
        res.body_count    = total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_mode_reg      <= 1'b0;
            content_length_reg <= '0;
            max_body_size_reg  <= MAX_BODY_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_BODY_MODE:      body_mode_reg      <= cfg_wdata[0];
                CFG_CONTENT_LENGTH: content_length_reg <= cfg_wdata;
                CFG_MAX_BODY_SIZE:  max_body_size_reg  <= cfg_wdata;
                default: begin
                    body_mode_reg <= body_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIZE;
            acc_reg   <= '0;
            left_reg  <= '0;
            total_reg <= '0;
            seen_reg  <= 1'b0;
            text_reg  <= 1'b0;
            done_reg  <= 1'b0;
            err_reg   <= ERR_NONE;
        end else if (in_xfer) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            seen_reg  <= seen_next;
            text_reg  <= text_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

@@ design/http_body_dechunker_top.sv @@
// Top level of the HTTP body dechunker: parser core and output register with skid
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: data_byte, new_body
//  m_       out  m_tvalid/m_tready  m_tdata: payload_byte .. body_count
//  cfg_     in   cfg_we             cfg_addr, cfg_wdata
//
// One byte per cycle while s_tready is high; each transfer in yields one registered transfer out.
// The parser state updates in the cycle of the input transfer.
// A stalled output parks one result in a skid register; s_tready drops only then.
// aresetn is synchronous: clears parser state, config to defaults, both output slots.
`default_nettype none

module http_body_dechunker_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // [7:0] data_byte, [8] new_body, [15:9] zero
    input  wire logic [dchk_pkg::S_TDATA_W-1:0]  s_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] payload_byte, [8] payload_valid, [9] body_done, [11:10] error_code,
    // [43:12] body_count, [47:44] zero
    output      logic [dchk_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [dchk_pkg::CFG_A_W-1:0]    cfg_addr,
    input  wire logic [dchk_pkg::CFG_D_W-1:0]    cfg_wdata
);
    import dchk_pkg::*;

    logic    in_xfer, out_xfer;
    result_t res;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(result_t))'(0), out_reg};

    dchk_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_xfer   (in_xfer),
        .data_byte (s_tdata[DATA_W-1:0]),
        .new_body  (s_tdata[DATA_W]),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .res       (res)
    );

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_xfer || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_xfer) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (in_xfer) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

@@ design/dchk_checker.sv @@
// Port-level checks for the HTTP body dechunker, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module dchk_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [dchk_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dchk_pkg::*;

    logic             out_stall;
    logic             out_pay;
    logic             out_done;
    logic [ERR_W-1:0] out_err;
    logic             pay_clean;

    assign out_stall = m_tvalid && !m_tready;
    assign out_pay   = m_tvalid && m_tdata[8];
    assign out_done  = m_tvalid && m_tdata[9];
    assign out_err   = m_tdata[11:10];
    assign pay_clean = (out_err == ERR_NONE) && (m_tdata[43:12] != '0);

    `CHK_ASSERT(a_out_hold, aclk, aresetn, out_stall |=> m_tvalid && $stable(m_tdata), "not held")
    `CHK_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `CHK_ASSERT(a_stall_backed, aclk, aresetn, !s_tready |-> m_tvalid, "stall with no output")
    `CHK_ASSERT(a_payload_clean, aclk, aresetn, out_pay |-> pay_clean, "payload flags bad")
    `CHK_ASSERT(a_done_no_err, aclk, aresetn, out_done |-> out_err == ERR_NONE, "done with error")

endmodule

bind http_body_dechunker_top dchk_checker u_dchk_checker (.*);

`default_nettype wire

@@ sim/dechunk_checker.sv @@
// Checker for the body dechunker: predicts each result from the input transfers and compares
`timescale 1ns / 100ps

module dechunk_checker
    import dchk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [CFG_D_W-1:0]   cfg_wdata,
    output int                   mismatches,
    output int                   outstanding
);

    logic               chunked_mode;
    logic [CNT_W-1:0]   declared_len;
    logic [CNT_W-1:0]   size_cap;

    logic [PHASE_W-1:0] parse_phase;
    logic [CNT_W-1:0]   size_acc;
    logic [CNT_W-1:0]   chunk_left;
    logic [CNT_W-1:0]   payload_total;
    logic               digit_seen;
    logic               line_text;
    logic               body_finished;
    logic [ERR_W-1:0]   body_err;

    result_t            decoded_q[$];
    result_t            want;
    result_t            got;
    result_t            next_result;
    int                 fail_tally = 0;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic int hex_nibble(input logic [DATA_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    task automatic clear_parser();
        parse_phase   = PH_SIZE;
        size_acc      = '0;
        chunk_left    = '0;
        payload_total = '0;
        digit_seen    = 1'b0;
        line_text     = 1'b0;
        body_finished = 1'b0;
        body_err      = ERR_NONE;
    endtask

    task automatic size_line_char(input logic [DATA_W-1:0] c);
        int nib;
        nib = hex_nibble(c);
        if (c == CHAR_CR) return;
        if (c == CHAR_LF) begin
            if (!digit_seen) begin
                if (line_text) body_err = ERR_BAD_LINE;
                line_text = 1'b0;
                return;
            end
            if ({1'b0, payload_total} + {1'b0, size_acc} > {1'b0, size_cap}) begin
                body_err = ERR_TOO_BIG;
                return;
            end
            chunk_left  = size_acc;
            parse_phase = (size_acc == '0) ? PH_TERM : PH_DATA;
            size_acc    = '0;
            digit_seen  = 1'b0;
            line_text   = 1'b0;
            return;
        end
        if (nib < 0 || line_text) begin
            line_text = 1'b1;
            return;
        end
        if (size_acc > 32'h0FFF_FFFF) begin
            body_err = ERR_TOO_BIG;
            return;
        end
        size_acc   = (size_acc << 4) + CNT_W'(nib);
        digit_seen = 1'b1;
    endtask

    task automatic decode_byte(input logic [DATA_W-1:0] c, input logic fresh,
                               output result_t r);
        logic taken;
        taken = 1'b0;
        if (fresh) clear_parser();
        if (!body_finished && body_err == ERR_NONE) begin
            if (!chunked_mode) begin
                if (declared_len > size_cap) begin
                    body_err = ERR_TOO_BIG;
                end else if (payload_total >= declared_len) begin
                    body_finished = 1'b1;
                end else begin
                    taken         = 1'b1;
                    payload_total = payload_total + 1;
                    if (payload_total >= declared_len) body_finished = 1'b1;
                end
            end else begin
                case (parse_phase)
                    PH_DATA: begin
                        taken         = 1'b1;
                        payload_total = payload_total + 1;
                        chunk_left    = chunk_left - 1;
                        if (chunk_left == '0) parse_phase = PH_CR;
                    end
                    PH_CR: begin
                        if (c == CHAR_CR) parse_phase = PH_LF;
                        else body_err = ERR_BAD_LINE;
                    end
                    PH_LF: begin
                        if (c == CHAR_LF) parse_phase = PH_SIZE;
                        else body_err = ERR_BAD_LINE;
                    end
                    PH_TERM: begin
                        if (c == CHAR_LF) body_finished = 1'b1;
                        else if (c != CHAR_CR) body_err = ERR_BAD_TERM;
                    end
                    default: begin
                        parse_phase = PH_SIZE;
                        size_line_char(c);
                    end
                endcase
            end
        end
        r.payload_byte  = c;
        r.payload_valid = taken;
        r.body_done     = body_finished;
        r.error_code    = body_err;
        r.body_count    = payload_total;
    endtask

    task automatic check_field(input string fname, input logic [CNT_W-1:0] exp_v,
                               input logic [CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
            fail_tally++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            chunked_mode = 1'b0;
            declared_len = '0;
            size_cap     = MAX_BODY_RESET;
            clear_parser();
            decoded_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, expected none, got %0h",
                             $time, m_tdata);
                    fail_tally++;
                end else begin
                    want = decoded_q.pop_front();
                    got  = result_t'(m_tdata[$bits(result_t)-1:0]);
                    check_field("payload_byte", CNT_W'(want.payload_byte), CNT_W'(got.payload_byte));
                    check_field("payload_valid", CNT_W'(want.payload_valid),
                                CNT_W'(got.payload_valid));
                    check_field("body_done", CNT_W'(want.body_done), CNT_W'(got.body_done));
                    check_field("error_code", CNT_W'(want.error_code), CNT_W'(got.error_code));
                    check_field("body_count", want.body_count, got.body_count);
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_BODY_MODE:      chunked_mode = cfg_wdata[0];
                    CFG_CONTENT_LENGTH: declared_len = cfg_wdata;
                    CFG_MAX_BODY_SIZE:  size_cap     = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata[DATA_W-1:0], s_tdata[DATA_W], next_result);
                decoded_q.push_back(next_result);
            end
        end
        mismatches  <= fail_tally;
        outstanding <= decoded_q.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for the body dechunker: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb;
    import dchk_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int TARGET_ITEMS = 1800;
    localparam int FRESH_BIT    = DATA_W;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_A_W-1:0]   cfg_addr  = CFG_BODY_MODE;
    logic [CFG_D_W-1:0]   cfg_wdata = '0;

    int mismatches;
    int outstanding;

    logic [DATA_W:0] beat_q[$];
    int              burst_left = 0;
    bit              steady     = 1'b0;
    int              items_sent = 0;
    int              bodies_sent = 0;
    int              settings_used = 0;
    int              cycles = 0;
    int              rx_tick = 0;
    int              rx_style = 0;

    logic             shadow_mode = 1'b0;
    logic [CNT_W-1:0] shadow_len  = '0;

    always #10 aclk = ~aclk;

    http_body_dechunker_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    dechunk_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        rx_tick++;
        if (rx_tick % 150 == 0) rx_style = $urandom_range(0, 3);
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_tick % 16 < 11);
        endcase
    end

    task automatic send_beat(input logic [DATA_W:0] beat);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tdata  <= S_TDATA_W'(beat);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [2:0] sel, input logic mode_v,
                              input logic [CNT_W-1:0] len_v, input logic [CNT_W-1:0] cap_v);
        for (int i = 0; i < 3; i++) begin
            if (sel[i]) begin
                cfg_we <= 1'b1;
                case (i)
                    0: begin
                        cfg_addr    <= CFG_BODY_MODE;
                        cfg_wdata   <= CFG_D_W'(mode_v);
                        shadow_mode  = mode_v;
                    end
                    1: begin
                        cfg_addr   <= CFG_CONTENT_LENGTH;
                        cfg_wdata  <= len_v;
                        shadow_len  = len_v;
                    end
                    default: begin
                        cfg_addr  <= CFG_MAX_BODY_SIZE;
                        cfg_wdata <= cap_v;
                    end
                endcase
                @(posedge aclk);
            end
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic add_char(input logic [DATA_W-1:0] c);
        beat_q.push_back({1'b0, c});
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) add_char(txt[i]);
    endtask

    function automatic logic [DATA_W-1:0] hex_char(input logic [3:0] nib);
        if (nib < 10) return 8'h30 + DATA_W'(nib);
        return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + DATA_W'(nib) - 8'd10;
    endfunction

    task automatic add_hex(input logic [CNT_W-1:0] v, input int zeros);
        int digits;
        digits = 1;
        while (digits < 8 && (v >> (4 * digits)) != 0) digits++;
        repeat (zeros) add_char(8'h30);
        for (int k = digits - 1; k >= 0; k--) add_char(hex_char(v[4*k +: 4]));
    endtask

    task automatic add_line_end();
        if ($urandom_range(0, 2) != 0) add_char(CHAR_CR);
        add_char(CHAR_LF);
    endtask

    task automatic send_text(input string txt);
        beat_q.delete();
        add_text(txt);
        beat_q[0][FRESH_BIT] = 1'b1;
        foreach (beat_q[i]) send_beat(beat_q[i]);
    endtask

    task automatic build_chunked();
        int flaw;
        int size_v;
        flaw = $urandom_range(0, 9);
        if (flaw == 1) begin
            add_char(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(8, 10)) add_char(hex_char(4'($urandom_range(0, 15))));
            add_line_end();
        end else if (flaw == 2) begin
            add_text(" 5");
            add_line_end();
        end
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 7) == 0) add_line_end();
            size_v = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            add_hex(CNT_W'(size_v), $urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0) begin
                add_char(8'h3B);
                repeat ($urandom_range(0, 4)) add_char(DATA_W'($urandom_range(32, 126)));
            end
            add_line_end();
            repeat (size_v) add_char(DATA_W'($urandom_range(0, 255)));
            add_char(CHAR_CR);
            add_char(CHAR_LF);
        end
        add_hex('0, $urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0) add_text(";end");
        add_line_end();
        if ($urandom_range(0, 3) == 0) add_char(CHAR_CR);
        add_char(CHAR_LF);
        if (flaw == 0) begin
            beat_q[$urandom_range(0, beat_q.size() - 1)] = {1'b0, DATA_W'($urandom_range(0, 255))};
        end else if (flaw == 3) begin
            beat_q.insert(beat_q.size() - 1, {1'b0, DATA_W'($urandom_range(32, 126))});
        end
    endtask

    task automatic build_fixed();
        int n;
        n = (shadow_len <= 40) ? int'(shadow_len) : $urandom_range(1, 40);
        if (n == 0) n = 1;
        repeat (n) add_char(DATA_W'($urandom_range(0, 255)));
    endtask

    function automatic logic [CNT_W-1:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            5:       return $urandom;
            default: return CNT_W'($urandom_range(1, 30));
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_cap();
        case ($urandom_range(0, 5))
            0:       return '0;
            2:       return CNT_W'($urandom_range(0, 60));
            3:       return $urandom;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    initial begin
        logic [2:0] sel;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fixed mode at reset values: empty body, then a sticky byte
        beat_q.delete();
        send_beat({1'b1, 8'h00});
        send_beat({1'b0, 8'hFF});
        drain();
        write_regs(3'b111, 1'b0, 32'd3, 32'd2);
        send_beat({1'b1, 8'h78});
        drain();
        write_regs(3'b100, 1'b0, '0, 32'hFFFF_FFFF);
        send_text("\377ab\000");
        drain();
        write_regs(3'b111, 1'b1, 32'hFFFF_FFFF, 32'd5);
        send_text("1x\015\012Z\015\012\015\012\060\015\012Q!");
        send_text(" 1\n");
        send_text("6\n");
        send_text("1\nab");
        send_text("123456789");

        while (items_sent < TARGET_ITEMS) begin
            drain();
            sel = (settings_used < 5) ? 3'b111 : 3'($urandom_range(1, 7));
            write_regs(sel, 1'($urandom_range(0, 1)), pick_len(), pick_cap());
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 5)) begin
                beat_q.delete();
                if ($urandom_range(0, 11) == 0) begin
                    repeat ($urandom_range(1, 20)) begin
                        beat_q.push_back({1'($urandom_range(0, 7) == 0),
                                          DATA_W'($urandom_range(0, 255))});
                    end
                end else if (shadow_mode) begin
                    build_chunked();
                end else begin
                    build_fixed();
                end
                beat_q[0][FRESH_BIT] = ($urandom_range(0, 7) != 0);
                if ($urandom_range(0, 19) == 0)
                    beat_q[$urandom_range(0, beat_q.size() - 1)][FRESH_BIT] = 1'b1;
                items_sent += beat_q.size();
                bodies_sent++;
                foreach (beat_q[i]) send_beat(beat_q[i]);
                repeat ($urandom_range(0, 2)) send_beat({1'b0, DATA_W'($urandom_range(0, 255))});
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Sent %0d body bytes in %0d bodies across %0d register settings.",
                 items_sent, bodies_sent, settings_used);
        $display("Bodies mixed fixed and chunked coding with bad sizes, overflow and bad ends.");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ http_body_dechunker_top.f @@
+incdir+design
design/dchk_pkg.sv
design/dchk_core.sv
design/http_body_dechunker_top.sv
design/dchk_checker.sv
sim/dechunk_checker.sv
sim/tb.sv
